>>> sv/pvd_pkg.sv
// Shared types and constants of the PID velocity drive.
// Used by the datapath, the divider and the controller; depends on nothing.
package pvd_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = 17;
    localparam int DELTA_W   = 18;
    localparam int OPND_W    = 18;
    localparam int PROD_W    = 36;
    localparam int DIFF_W    = 34;
    localparam int SUM_W     = 52;
    localparam int CFG_IDX_W = 3;

    // Limit divider: 65536 / gain_i, two quotient bits per step
    localparam int DVD_W     = 18;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(65536);

    // Register reset values
    localparam logic [DATA_W-1:0] RST_GAIN_P        = 16'd256;
    localparam logic [DATA_W-1:0] RST_GAIN_I        = 16'd0;
    localparam logic [DATA_W-1:0] RST_GAIN_D        = 16'd0;
    localparam logic [DATA_W-1:0] RST_SAMPLE_PERIOD = 16'd66;
    localparam logic [DATA_W-1:0] RST_SAMPLE_RATE   = 16'd1000;
    localparam logic [DATA_W-1:0] RST_PWM_PERIOD    = 16'd999;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_SAMPLE_PERIOD = 3'd3,
        REG_SAMPLE_RATE   = 3'd4,
        REG_PWM_PERIOD    = 3'd5
    } t_reg_idx;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_SP,
        MUL_DELTA_SR,
        MUL_GI_ACC,
        MUL_GP_ERR,
        MUL_GD_DL,
        MUL_GD_DH,
        MUL_MAG_PWM
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    div_start;
        t_mul_op mul_op;
        logic    integ_en;
        logic    dsave_en;
        logic    clamp_en;
        logic    sum_init;
        logic    sum_add;
        logic    sum_add_hi;
        logic    sat_en;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

>>> sv/pvd_div.sv
// Radix-4 restoring divider that forms the integral limit 65536 / gain_i.
// Uses pvd_pkg; instantiated by the datapath.
module pvd_div
    import pvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_lim
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVD_W-1:0]     r_quo;

    logic [DATA_W:0]   t1, t2, dv;
    logic              ge1, ge2;
    logic [DATA_W-1:0] rem1, rem2;

    always_comb begin
        dv   = {1'b0, i_divisor};
        t1   = {r_rem, r_dvd[DVD_W-1]};
        ge1  = (t1 >= dv);
        rem1 = ge1 ? DATA_W'(t1 - dv) : t1[DATA_W-1:0];
        t2   = {rem1, r_dvd[DVD_W-2]};
        ge2  = (t2 >= dv);
        rem2 = ge2 ? DATA_W'(t2 - dv) : t2[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= DIVIDEND;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
            r_quo <= {r_quo[DVD_W-3:0], ge1, ge2};
        end
    end

    assign o_done = !r_busy;
    // Saturate: a gain of one gives 65535
    assign o_lim  = (|r_quo[DVD_W-1:DATA_W]) ? '1 : r_quo[DATA_W-1:0];

endmodule

>>> sv/pvd_dp.sv
// Datapath: configuration registers, loop state, shared 18x18 multiplier,
// accumulator, saturation and output registers. Uses pvd_pkg and pvd_div.
module pvd_dp
    import pvd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DATA_W-1:0]           i_cfg_data,
    input  logic signed [DATA_W-1:0]    i_target_speed,
    input  logic signed [DATA_W-1:0]    i_measured_speed,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    output logic [DATA_W-1:0]           o_pulse_magnitude,
    output logic                        o_dir_a,
    output logic                        o_dir_b
);

    logic [DATA_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [DATA_W-1:0] r_sample_period, r_sample_rate, r_pwm_period;

    logic signed [ERR_W-1:0]   r_integ, r_prev, r_err, r_acc;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [DIFF_W-1:0]  r_d;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic [DATA_W-1:0]         r_mag;
    logic                      r_neg;
    logic [DATA_W-1:0]         r_pulse;
    logic                      r_dir_a, r_dir_b;

    logic signed [ERR_W-1:0]   err_c;
    logic signed [DELTA_W-1:0] delta_c;
    logic signed [OPND_W-1:0]  opa, opb;
    logic signed [PROD_W-1:0]  prod_c, rnd_c;
    logic signed [DELTA_W-1:0] step_c;
    logic signed [ERR_W+1:0]   acc_sum;
    logic signed [ERR_W-1:0]   acc_sat, acc_cl;
    logic signed [DELTA_W-1:0] u_sat, u_abs;
    logic [DATA_W-1:0]         pulse_c;
    logic                      negp_c;
    logic                      div_done;
    logic [DATA_W-1:0]         lim;

    pvd_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (r_gain_i),
        .o_done    (div_done),
        .o_lim     (lim)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p        <= RST_GAIN_P;
            r_gain_i        <= RST_GAIN_I;
            r_gain_d        <= RST_GAIN_D;
            r_sample_period <= RST_SAMPLE_PERIOD;
            r_sample_rate   <= RST_SAMPLE_RATE;
            r_pwm_period    <= RST_PWM_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN_P:        r_gain_p        <= i_cfg_data;
                REG_GAIN_I:        r_gain_i        <= i_cfg_data;
                REG_GAIN_D:        r_gain_d        <= i_cfg_data;
                REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                REG_SAMPLE_RATE:   r_sample_rate   <= i_cfg_data;
                REG_PWM_PERIOD:    r_pwm_period    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        err_c   = ERR_W'(i_target_speed) - ERR_W'(i_measured_speed);
        delta_c = DELTA_W'(err_c) - DELTA_W'(r_prev);

        case (i_cmd.mul_op)
            MUL_ERR_SP: begin
                opa = OPND_W'(r_err);
                opb = {2'b00, r_sample_period};
            end
            MUL_DELTA_SR: begin
                opa = r_delta;
                opb = {2'b00, r_sample_rate};
            end
            MUL_GI_ACC: begin
                opa = {2'b00, r_gain_i};
                opb = OPND_W'(r_acc);
            end
            MUL_GP_ERR: begin
                opa = {2'b00, r_gain_p};
                opb = OPND_W'(r_err);
            end
            MUL_GD_DL: begin
                opa = {2'b00, r_gain_d};
                opb = {1'b0, r_d[ERR_W-1:0]};
            end
            MUL_GD_DH: begin
                opa = {2'b00, r_gain_d};
                opb = {r_d[DIFF_W-1], r_d[DIFF_W-1:ERR_W]};
            end
            MUL_MAG_PWM: begin
                opa = {2'b00, r_mag};
                opb = {2'b00, r_pwm_period};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        prod_c = opa * opb;

        // Integral step, truncated toward zero to Q8.8
        rnd_c   = r_prod + (r_prod[PROD_W-1] ? PROD_W'(65535) : '0);
        step_c  = rnd_c[33:16];
        acc_sum = (ERR_W+2)'(r_integ) + (ERR_W+2)'(step_c);
        if (acc_sum > (ERR_W+2)'(65535)) begin
            acc_sat = ERR_W'(65535);
        end else if (acc_sum < -(ERR_W+2)'(65536)) begin
            acc_sat = -ERR_W'(65536);
        end else begin
            acc_sat = acc_sum[ERR_W-1:0];
        end

        // Anti-windup: r_prod holds gain_i * accumulated integral here
        acc_cl = r_acc;
        if (r_gain_i != '0) begin
            if (r_prod > PROD_W'(65536)) begin
                acc_cl = {1'b0, lim};
            end else if (r_prod < -PROD_W'(65536)) begin
                acc_cl = '0 - {1'b0, lim};
            end
        end

        if (r_sum > SUM_W'(65536)) begin
            u_sat = DELTA_W'(65536);
        end else if (r_sum < -SUM_W'(65536)) begin
            u_sat = -DELTA_W'(65536);
        end else begin
            u_sat = r_sum[DELTA_W-1:0];
        end
        u_abs = u_sat[DELTA_W-1] ? -u_sat : u_sat;

        pulse_c = r_prod[30:15];
        negp_c  = r_neg && (pulse_c != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prev <= err_c;
            end
            if (i_cmd.clamp_en) begin
                r_integ <= acc_cl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err   <= err_c;
            r_delta <= delta_c;
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= prod_c;
        end
        if (i_cmd.integ_en) begin
            r_acc <= acc_sat;
        end else if (i_cmd.clamp_en) begin
            r_acc <= acc_cl;
        end
        if (i_cmd.dsave_en) begin
            r_d <= r_prod[DIFF_W-1:0];
        end
        if (i_cmd.sum_init) begin
            r_sum <= SUM_W'(r_prod);
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end else if (i_cmd.sum_add_hi) begin
            // high half of the derivative product, weight 2^17
            r_sum <= r_sum + {r_prod[34:0], 17'b0};
        end
        if (i_cmd.sat_en) begin
            r_mag <= u_abs[DATA_W:1];
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.out_load) begin
            r_pulse <= pulse_c;
            r_dir_a <= !negp_c;
            r_dir_b <= negp_c;
        end
    end

    assign o_sts.div_done    = div_done;
    assign o_pulse_magnitude = r_pulse;
    assign o_dir_a           = r_dir_a;
    assign o_dir_b           = r_dir_b;

endmodule

>>> sv/pvd_ctrl.sv
// Controller: sequences the shared multiplier and accumulator per tick and
// owns the input and output handshakes. Uses pvd_pkg.
module pvd_ctrl
    import pvd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_INTEG,
        ST_DSAVE,
        ST_WAIT_DIV,
        ST_CLAMP,
        ST_SUM_P,
        ST_SUM_I,
        ST_SUM_DL,
        ST_SUM_DH,
        ST_SAT,
        ST_PWM,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_MUL_ERR;
                end
            end
            ST_MUL_ERR: begin
                o_cmd.mul_op = MUL_ERR_SP;
                n_state      = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.integ_en = 1'b1;
                o_cmd.mul_op   = MUL_DELTA_SR;
                n_state        = ST_DSAVE;
            end
            ST_DSAVE: begin
                o_cmd.dsave_en = 1'b1;
                o_cmd.mul_op   = MUL_GI_ACC;
                n_state        = ST_WAIT_DIV;
            end
            ST_WAIT_DIV: begin
                // hold until the integral limit is ready
                if (i_sts.div_done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                o_cmd.clamp_en = 1'b1;
                o_cmd.mul_op   = MUL_GP_ERR;
                n_state        = ST_SUM_P;
            end
            ST_SUM_P: begin
                o_cmd.sum_init = 1'b1;
                o_cmd.mul_op   = MUL_GI_ACC;
                n_state        = ST_SUM_I;
            end
            ST_SUM_I: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.mul_op  = MUL_GD_DL;
                n_state       = ST_SUM_DL;
            end
            ST_SUM_DL: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.mul_op  = MUL_GD_DH;
                n_state       = ST_SUM_DH;
            end
            ST_SUM_DH: begin
                o_cmd.sum_add_hi = 1'b1;
                n_state          = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat_en = 1'b1;
                n_state      = ST_PWM;
            end
            ST_PWM: begin
                o_cmd.mul_op = MUL_MAG_PWM;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to drain
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/pid_velocity_pwm_drive.sv
// PID velocity controller with integral anti-windup, driving a PWM H-bridge.
// A tick runs from acceptance to the result sitting in the output register.
// Its length is set by the single shared 18x18 multiplier that performs the
// eight products of a tick one after another, and by the nine-step divider
// forming the anti-windup limit from gain_i, which runs beside the first
// products. The next tick is taken as soon as the previous result has been
// loaded into the output register, even while that beat is stalled downstream.
// The user must write registers only while idle; the block does not enforce it.
module pid_velocity_pwm_drive
    import pvd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_target_speed,
    input  logic signed [DATA_W-1:0] i_measured_speed,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [DATA_W-1:0]        o_pulse_magnitude,
    output logic                     o_dir_a,
    output logic                     o_dir_b
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    pvd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pvd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_target_speed    (i_target_speed),
        .i_measured_speed  (i_measured_speed),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_pulse_magnitude (o_pulse_magnitude),
        .o_dir_a           (o_dir_a),
        .o_dir_b           (o_dir_b)
    );

endmodule

>>> sv/pvd_checker.sv
// Port-level checks of the PID velocity drive, bound to the top level.
// Depends only on the top level's ports.
module pvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_stall,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [15:0] i_pulse_magnitude,
    input logic        i_dir_a,
    input logic        i_dir_b
);

    // While a beat is valid, bridge pins are never both driven or both released
    a_dir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_dir_a ^ i_dir_b))
        else $error("direction pins not exclusive");

    // Reverse drive never comes with a zero pulse
    a_rev_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_dir_b) |-> (i_pulse_magnitude != 16'd0))
        else $error("reverse direction with zero pulse");

    // Busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("input taken again without processing");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=>
            (i_out_valid && $stable(i_pulse_magnitude) && $stable(i_dir_a)))
        else $error("stalled result changed");

endmodule

bind pid_velocity_pwm_drive pvd_checker u_pvd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .i_in_stall        (o_in_stall),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_pulse_magnitude (o_pulse_magnitude),
    .i_dir_a           (o_dir_a),
    .i_dir_b           (o_dir_b)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench of pid_velocity_pwm_drive: a directed table, then random phases.
// Uses pvd_pkg and the drive top level; every beat is checked against the table or a predictor.
module testbench;
    import pvd_pkg::*;

    localparam int NUM_REGS    = 6;
    localparam int WATCHDOG    = 2000;
    localparam int SETTLE      = 40;
    localparam int PHASES      = 12;
    localparam int PHASE_TICKS = 95;
    localparam int PLAN_ROWS   = 25;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint UNITY    = 65536;
    localparam longint INTEG_HI = 65535;
    localparam longint INTEG_LO = -65536;

    typedef struct packed {
        logic [DATA_W-1:0] mag;
        logic              dir_a;
        logic              dir_b;
    } drive_beat;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind;

    typedef struct {
        row_kind                  kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [DATA_W-1:0]        data;
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        logic                     known;
        logic [DATA_W-1:0]        mag;
        logic                     dir_a;
        logic                     dir_b;
    } stim_row;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [DATA_W-1:0]        cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic signed [DATA_W-1:0] target     = '0;
    logic signed [DATA_W-1:0] measured   = '0;
    logic                     out_stall  = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [DATA_W-1:0]        o_pulse_magnitude;
    logic                     o_dir_a;
    logic                     o_dir_b;

    // predictor state and register copies
    logic [DATA_W-1:0] reg_shadow [NUM_REGS];
    longint            integ_acc = 0;
    longint            last_err  = 0;
    drive_beat         pending_drive [$];
    stim_row           plan [PLAN_ROWS];
    bit                send_calm = 1'b0;
    bit                recv_calm = 1'b0;
    int                errors    = 0;

    pid_velocity_pwm_drive dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_target_speed    (target),
        .i_measured_speed  (measured),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_pulse_magnitude (o_pulse_magnitude),
        .o_dir_a           (o_dir_a),
        .o_dir_b           (o_dir_b)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [DATA_W-1:0] draw_setting();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'd1;
            2: return '1;
            3, 4: return 16'($urandom_range(1, 600));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rail_speed();
        case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    // One control tick: integral with anti-windup, derivative, saturated PWM drive.
    function automatic drive_beat pid_tick(input logic signed [DATA_W-1:0] tgt,
                                           input logic signed [DATA_W-1:0] meas);
        longint kp, ki, kd, ts, fs, pwm;
        longint err, acc, lim, prod, diff, u, mag15, pulse;
        logic negp;
        drive_beat beat;
        kp  = reg_shadow[REG_GAIN_P];
        ki  = reg_shadow[REG_GAIN_I];
        kd  = reg_shadow[REG_GAIN_D];
        ts  = reg_shadow[REG_SAMPLE_PERIOD];
        fs  = reg_shadow[REG_SAMPLE_RATE];
        pwm = reg_shadow[REG_PWM_PERIOD];
        err = longint'(tgt) - longint'(meas);
        // division truncates toward zero, as the Q8.24 to Q8.8 step requires
        acc = integ_acc + (err * ts) / UNITY;
        if (acc > INTEG_HI) acc = INTEG_HI;
        else if (acc < INTEG_LO) acc = INTEG_LO;
        if (ki != 0) begin
            lim  = UNITY / ki;
            prod = ki * acc;
            if (lim > INTEG_HI) lim = INTEG_HI;
            if (prod > UNITY) acc = lim;
            else if (prod < -UNITY) acc = -lim;
        end
        integ_acc = acc;
        diff      = (err - last_err) * fs;
        last_err  = err;
        u = kp * err + ki * acc + kd * diff;
        if (u > UNITY) u = UNITY;
        else if (u < -UNITY) u = -UNITY;
        mag15      = (u < 0 ? -u : u) >> 1;
        pulse      = (mag15 * pwm) >> 15;
        negp       = (u < 0) && (pulse != 0);
        beat.mag   = pulse[DATA_W-1:0];
        beat.dir_a = !negp;
        beat.dir_b = negp;
        return beat;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx < NUM_REGS) reg_shadow[idx] = val;
    endtask

    // Drop valid and hold until every expected beat has come back.
    task automatic drain_ticks();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_drive.size() != 0);
    endtask

    task automatic send_tick(input logic signed [DATA_W-1:0] tgt,
                             input logic signed [DATA_W-1:0] meas,
                             input logic known, input drive_beat typed);
        int gap;
        drive_beat want;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        target   <= tgt;
        measured <= meas;
        do @(posedge clk); while (o_in_stall);
        want = pid_tick(tgt, meas);
        pending_drive.push_back(known ? typed : want);
    endtask

    task automatic draw_speeds(output logic signed [DATA_W-1:0] tgt,
                               output logic signed [DATA_W-1:0] meas);
        tgt = 16'($urandom);
        case ($urandom_range(0, 3))
            0: meas = 16'($urandom);
            1: meas = tgt + 16'($urandom_range(0, 64)) - 16'sd32;
            2: begin
                tgt  = rail_speed();
                meas = rail_speed();
            end
            default: meas = tgt + 16'($urandom_range(0, 4000)) - 16'sd2000;
        endcase
    endtask

    // Receiver: before each beat, stall for a random wait from draw_wait (none when calm).
    initial begin
        int hold;
        forever begin
            hold = draw_wait(recv_calm);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && o_out_valid));
        end
    end

    always @(posedge clk) begin : check_beat
        drive_beat want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_drive.size() == 0) begin
                $error("unexpected beat: pulse_magnitude %0d", o_pulse_magnitude);
                errors++;
            end else begin
                want = pending_drive.pop_front();
                if (o_pulse_magnitude !== want.mag) begin
                    $error("pulse_magnitude: expected %0d, actual %0d",
                           want.mag, o_pulse_magnitude);
                    errors++;
                end
                if (o_dir_a !== want.dir_a) begin
                    $error("dir_a: expected %0b, actual %0b", want.dir_a, o_dir_a);
                    errors++;
                end
                if (o_dir_b !== want.dir_b) begin
                    $error("dir_b: expected %0b, actual %0b", want.dir_b, o_dir_b);
                    errors++;
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG) begin
            @(posedge clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("pid_velocity_pwm_drive: mismatch");
        $finish;
    end

    initial begin
        logic signed [DATA_W-1:0] tgt, meas;
        drive_beat none;
        drive_beat typed;
        none = '0;
        reg_shadow[REG_GAIN_P]        = RST_GAIN_P;
        reg_shadow[REG_GAIN_I]        = RST_GAIN_I;
        reg_shadow[REG_GAIN_D]        = RST_GAIN_D;
        reg_shadow[REG_SAMPLE_PERIOD] = RST_SAMPLE_PERIOD;
        reg_shadow[REG_SAMPLE_RATE]   = RST_SAMPLE_RATE;
        reg_shadow[REG_PWM_PERIOD]    = RST_PWM_PERIOD;
        plan = '{
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sd0,      16'sd0,      1'b1, 16'd0,   1'b1, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sh7FFF,   16'sh8000,   1'b1, 16'd999, 1'b1, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sh8000,   16'sh7FFF,   1'b1, 16'd999, 1'b0, 1'b1},
            '{ROW_CFG,  REG_GAIN_P,        16'd1,     16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            // drive of minus one LSB truncates to a zero, non-negative pulse
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sd0,      16'sd1,      1'b1, 16'd0,   1'b1, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     -16'sd5,     16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_GAIN_P,        16'd0,     16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_GAIN_I,        16'hFFFF,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sh7FFF,   16'sh8000,   1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sh8000,   16'sh7FFF,   1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_GAIN_D,        16'hFFFF,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_SAMPLE_RATE,   16'hFFFF,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sd100,    -16'sd100,   1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     -16'sd100,   16'sd100,    1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_SAMPLE_PERIOD, 16'hFFFF,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sd5000,   -16'sd5000,  1'b0, 16'd0,   1'b0, 1'b0},
            // zero period, rate and PWM period are taken as written
            '{ROW_CFG,  REG_SAMPLE_PERIOD, 16'd0,     16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_SAMPLE_RATE,   16'd0,     16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sd1234,   16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_PWM_PERIOD,    16'd0,     16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sh7FFF,   16'sh8000,   1'b1, 16'd0,   1'b1, 1'b0},
            '{ROW_CFG,  REG_PWM_PERIOD,    16'hFFFF,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            // writes past the register list must leave everything alone
            '{ROW_CFG,  REG_SPARE_LO,      16'hFFFF,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_CFG,  REG_SPARE_HI,      16'h1234,  16'sd0,      16'sd0,      1'b0, 16'd0,   1'b0, 1'b0},
            '{ROW_TICK, REG_GAIN_P,        16'd0,     16'sh8000,   16'sh7FFF,   1'b0, 16'd0,   1'b0, 1'b0}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                drain_ticks();
                write_reg(plan[k].idx, plan[k].data);
                cfg_valid <= 1'b0;
            end else begin
                typed = '{plan[k].mag, plan[k].dir_a, plan[k].dir_b};
                send_tick(plan[k].tgt, plan[k].meas, plan[k].known, typed);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_ticks();
            for (int r = 0; r < NUM_REGS; r++) write_reg(CFG_IDX_W'(r), draw_setting());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
            cfg_valid <= 1'b0;
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if ($urandom_range(0, 39) == 0) drain_ticks();
                draw_speeds(tgt, meas);
                send_tick(tgt, meas, 1'b0, none);
            end
        end

        drain_ticks();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("pid_velocity_pwm_drive: match");
        else
            $display("pid_velocity_pwm_drive: mismatch");
        $finish;
    end

endmodule
